/* rtl/gma_pkg.sv */
`default_nettype none

package gma_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LIMIT_W = 15;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd5120;
	localparam int WINDOW_DEFAULT = 5;
	// quotient bits resolved per divider cycle
	localparam int DIV_RADIX_BITS = 4;

endpackage

`default_nettype wire

/* rtl/gma_div.sv */
`default_nettype none

module gma_div
	import gma_pkg::*;
#(
	parameter int DW = 20,
	parameter int CW = 3
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [DW-1:0]       dividend,
	input  wire logic [CW-1:0]       divisor,
	input  wire logic                neg,
	output logic                     done,
	output logic signed [SAMPLE_W-1:0] quotient
);

	localparam int STEPS = DW / DIV_RADIX_BITS;
	localparam int SCW = $clog2(STEPS + 1);

	logic [DW-1:0] dvd_q;
	logic [DW-1:0] quo_q;
	logic [CW:0] rem_q;
	logic [CW-1:0] dsr_q;
	logic neg_q;
	logic busy_q;
	logic done_q;
	logic [SCW-1:0] step_q;

	logic [DW-1:0] dvd_n;
	logic [DW-1:0] quo_n;
	logic [CW:0] rem_n;
	logic [DW-1:0] quo_signed;

	// restoring division, a few quotient bits per cycle
	always_comb begin
		dvd_n = dvd_q;
		quo_n = quo_q;
		rem_n = rem_q;
		for (int i = 0; i < DIV_RADIX_BITS; i++) begin
			rem_n = {rem_n[CW-1:0], dvd_n[DW-1]};
			dvd_n = {dvd_n[DW-2:0], 1'b0};
			quo_n = {quo_n[DW-2:0], 1'b0};
			if (rem_n >= {1'b0, dsr_q}) begin
				rem_n = rem_n - {1'b0, dsr_q};
				quo_n[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SCW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			quo_q <= '0;
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			dvd_q <= dvd_n;
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
	end

	assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quotient = quo_signed[SAMPLE_W-1:0];
	assign done = done_q;

endmodule

`default_nettype wire

/* rtl/gated_moving_average.sv */
`default_nettype none

// Windowed mean of signed Q8.8 velocity samples with outlier gating. Each
// transaction on the input channel yields exactly one result: the mean of the
// last WINDOW accepted samples (fewer until the window has filled), truncated
// toward zero, or, once the window is full and the sample lies farther than
// deviation_limit from the last reported mean, the previous mean again with
// sample_rejected set. Samples live in a small one-port-read memory; a running
// sum is updated by reading the entry being overwritten, and the mean comes
// from a radix-16 divider. An accepted sample passes through S_READ, S_START
// and S_DIV to S_OUT, where the result is loaded into the output register; a
// rejected sample goes from S_READ straight to S_OUT. The block takes a new
// sample as soon as the previous result sits in the output register, even
// while that is stalled.
// deviation_limit may be written only while the block is idle.
module gated_moving_average
	import gma_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [LIMIT_W-1:0]         cfg_wr_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic signed [SAMPLE_W-1:0] velocity_sample,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed [SAMPLE_W-1:0]      average_velocity,
	output logic                            sample_rejected
);

	localparam int SLW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = $clog2(WINDOW + 1);
	localparam int SW = SAMPLE_W + $clog2(WINDOW);
	localparam int DIV_STEPS = (SW + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
	localparam int DW = DIV_STEPS * DIV_RADIX_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_START,
		S_DIV,
		S_OUT
	} state_t;

	state_t state_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [SLW-1:0] slot_q;
	logic full_q;
	logic [CW-1:0] count_q;
	logic signed [SW-1:0] sum_q;
	logic signed [SAMPLE_W-1:0] last_avg_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic reject_q;
	logic signed [SAMPLE_W-1:0] result_q;
	logic out_valid_q;
	logic signed [SAMPLE_W-1:0] out_avg_q;
	logic out_rej_q;

	logic [SAMPLE_W-1:0] mem [WINDOW];
	logic signed [SAMPLE_W-1:0] rd_q;
	logic mem_we;

	logic in_accept;
	logic out_free;
	logic signed [SAMPLE_W:0] diff;
	logic [SAMPLE_W:0] distance;
	logic reject_now;
	logic signed [SW-1:0] old_val;
	logic [SW-1:0] sum_mag;
	logic div_done;
	logic signed [SAMPLE_W-1:0] div_quot;

	assign in_stall = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign diff = (SAMPLE_W + 1)'(velocity_sample) - (SAMPLE_W + 1)'(last_avg_q);
	assign distance = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
	assign reject_now = full_q && (distance > (SAMPLE_W + 1)'(limit_q));

	// entry about to be overwritten leaves the running sum
	assign old_val = full_q ? SW'(rd_q) : '0;
	assign sum_mag = sum_q[SW-1] ? (~sum_q + 1'b1) : sum_q;
	assign mem_we = (state_q == S_READ) && !reject_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_q] <= sample_q;
		end
		rd_q <= mem[slot_q];
	end

	gma_div #(
		.DW(DW),
		.CW(CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_START),
		.dividend (DW'(sum_mag)),
		.divisor  (count_q),
		.neg      (sum_q[SW-1]),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			limit_q <= LIMIT_RESET;
			slot_q <= '0;
			full_q <= 1'b0;
			count_q <= '0;
			sum_q <= '0;
			last_avg_q <= '0;
			out_valid_q <= 1'b0;
			sample_q <= '0;
			reject_q <= 1'b0;
			result_q <= '0;
			out_avg_q <= '0;
			out_rej_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						sample_q <= velocity_sample;
						reject_q <= reject_now;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (reject_q) begin
						result_q <= last_avg_q;
						state_q <= S_OUT;
					end else begin
						sum_q <= sum_q + SW'(sample_q) - old_val;
						if (slot_q == SLW'(WINDOW - 1)) begin
							slot_q <= '0;
							full_q <= 1'b1;
						end else begin
							slot_q <= slot_q + 1'b1;
						end
						if (count_q != CW'(WINDOW)) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= S_START;
					end
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						result_q <= div_quot;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_avg_q <= result_q;
						out_rej_q <= reject_q;
						last_avg_q <= result_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign average_velocity = out_avg_q;
	assign sample_rejected = out_rej_q;

	a_reject_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && reject_q) |-> full_q)
		else $error("sample rejected before window filled");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (count_q == CW'(WINDOW)))
		else $error("window full but count short");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside divide state");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLW'(WINDOW - 1))
		else $error("write slot out of range");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_avg_q)))
		else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
